/* hw/rtl/sfr_pkg.sv */
package sfr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 11;
	localparam int Q_DEPTH = 4;

	localparam logic [BYTE_W-1:0] FLAG_BYTE    = 8'h7E;
	localparam logic [BYTE_W-1:0] CTL_I0       = 8'h00;
	localparam logic [BYTE_W-1:0] CTL_I1       = 8'h80;
	localparam logic [BYTE_W-1:0] CTL_SET      = 8'h03;
	localparam logic [BYTE_W-1:0] UNSTUFF      = 8'h20;
	localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'h03;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

	typedef enum logic {
		REG_STATION_ADDRESS = 1'b0,
		REG_ESCAPE_BYTE     = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_BYTE = 3'd0,
		EV_GOOD = 3'd1,
		EV_DUP  = 3'd2,
		EV_BAD  = 3'd3,
		EV_HDR  = 3'd4,
		EV_OVF  = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		RP_NONE = 3'd0,
		RP_UA   = 3'd1,
		RP_RR0  = 3'd2,
		RP_RR1  = 3'd3,
		RP_REJ0 = 3'd4,
		RP_REJ1 = 3'd5
	} reply_t;

	typedef enum logic [1:0] {
		TK_BYTE = 2'd0,
		TK_HDR  = 2'd1,
		TK_END  = 2'd2
	} tok_kind_t;

	// word passed from the frame parser to the reply stage
	typedef struct packed {
		tok_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              ovf;
		logic              bad;
		logic              ctl_i0;
		logic              ctl_i1;
	} token_t;

endpackage

/* hw/rtl/sfr_front.sv */
module sfr_front #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [sfr_pkg::BYTE_W-1:0]  cfg_data,
	input  logic                        accept,
	input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        emit,
	output sfr_pkg::token_t             token
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_FLAG = 3'd1,
		PH_ADDR = 3'd2,
		PH_CTRL = 3'd3,
		PH_BCC1 = 3'd4,
		PH_DATA = 3'd5,
		PH_ESC  = 3'd6
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [sfr_pkg::BYTE_W-1:0] addr_q, esc_q;
	logic [sfr_pkg::BYTE_W-1:0] ctl_q, ctl_d;
	logic [sfr_pkg::BYTE_W-1:0] held_q, held_d;
	logic                       hv_q, hv_d;
	logic [sfr_pkg::BYTE_W-1:0] chk_q, chk_d;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic                       ovf_q, ovf_d;
	logic                       do_take, clr, hdr_emit, end_emit, byte_emit;
	logic [sfr_pkg::BYTE_W-1:0] take_byte;
	logic [CNT_W-1:0]           cnt_m1;

	assign take_byte = (phase_q == PH_ESC) ? (rx_byte ^ sfr_pkg::UNSTUFF) : rx_byte;
	assign cnt_m1    = (cnt_q != '0) ? (cnt_q - CNT_W'(1)) : '0;

	always_comb begin
		phase_d  = phase_q;
		ctl_d    = ctl_q;
		do_take  = 1'b0;
		clr      = 1'b0;
		hdr_emit = 1'b0;
		end_emit = 1'b0;
		case (phase_q)
			PH_FLAG: begin
				if (rx_byte == addr_q) begin
					phase_d = PH_ADDR;
				end else if (rx_byte != sfr_pkg::FLAG_BYTE) begin
					phase_d = PH_HUNT;
				end
			end
			PH_ADDR: begin
				if (rx_byte inside {sfr_pkg::CTL_I0, sfr_pkg::CTL_I1, sfr_pkg::CTL_SET}) begin
					ctl_d   = rx_byte;
					phase_d = PH_CTRL;
				end else begin
					phase_d = (rx_byte == sfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_CTRL: begin
				if (rx_byte == (addr_q ^ ctl_q)) begin
					phase_d = PH_BCC1;
					clr     = 1'b1;
				end else begin
					phase_d = (rx_byte == sfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_BCC1: begin
				if (rx_byte == esc_q) begin
					phase_d = PH_ESC;
				end else if (rx_byte == sfr_pkg::FLAG_BYTE) begin
					phase_d  = PH_HUNT;
					hdr_emit = 1'b1;
				end else begin
					phase_d = PH_DATA;
					do_take = 1'b1;
				end
			end
			PH_ESC: begin
				phase_d = PH_DATA;
				do_take = 1'b1;
			end
			PH_DATA: begin
				if (rx_byte == sfr_pkg::FLAG_BYTE) begin
					phase_d  = PH_HUNT;
					end_emit = 1'b1;
				end else if (rx_byte == esc_q) begin
					phase_d = PH_ESC;
				end else begin
					do_take = 1'b1;
				end
			end
			default: begin
				phase_d = (rx_byte == sfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
			end
		endcase
	end

	always_comb begin
		held_d    = held_q;
		hv_d      = hv_q;
		chk_d     = chk_q;
		cnt_d     = cnt_q;
		ovf_d     = ovf_q;
		byte_emit = 1'b0;
		if (clr) begin
			held_d = '0;
			hv_d   = 1'b0;
			chk_d  = '0;
			cnt_d  = '0;
			ovf_d  = 1'b0;
		end else if (do_take && !ovf_q) begin
			if (hv_q && (cnt_q > CNT_MAX)) begin
				ovf_d = 1'b1;
			end else begin
				byte_emit = hv_q;
				chk_d     = chk_q ^ take_byte;
				cnt_d     = cnt_q + CNT_W'(1);
				held_d    = take_byte;
				hv_d      = 1'b1;
			end
		end
	end

	always_comb begin
		token        = '0;
		token.ctl_i0 = (ctl_q == sfr_pkg::CTL_I0);
		token.ctl_i1 = (ctl_q == sfr_pkg::CTL_I1);
		token.ovf    = ovf_q;
		token.bad    = (chk_q != '0) || (cnt_q < CNT_W'(2));
		if (hdr_emit) begin
			token.kind = sfr_pkg::TK_HDR;
		end else if (end_emit) begin
			token.kind = sfr_pkg::TK_END;
			token.len  = ovf_q ? sfr_pkg::LEN_W'(MAX_PAYLOAD) : sfr_pkg::LEN_W'(cnt_m1);
		end else begin
			token.kind = sfr_pkg::TK_BYTE;
			token.data = held_q;
		end
	end

	assign emit = accept && (hdr_emit || end_emit || byte_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= sfr_pkg::ADDR_RESET;
			esc_q   <= sfr_pkg::ESCAPE_RESET;
			phase_q <= PH_HUNT;
			ctl_q   <= '0;
			held_q  <= '0;
			hv_q    <= 1'b0;
			chk_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sfr_pkg::REG_STATION_ADDRESS: addr_q <= cfg_data;
					sfr_pkg::REG_ESCAPE_BYTE:     esc_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= phase_d;
				ctl_q   <= ctl_d;
				held_q  <= held_d;
				hv_q    <= hv_d;
				chk_q   <= chk_d;
				cnt_q   <= cnt_d;
				ovf_q   <= ovf_d;
			end
		end
	end

endmodule

/* hw/rtl/sfr_queue.sv */
module sfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfr_pkg::token_t push_data,
	output logic            full,
	input  logic            pop,
	output sfr_pkg::token_t pop_data,
	output logic            empty
);

	localparam int PTR_W = $clog2(sfr_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(sfr_pkg::Q_DEPTH + 1);

	sfr_pkg::token_t  mem_q [sfr_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(sfr_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/sfr_back.sv */
module sfr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  sfr_pkg::token_t            q_data,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output sfr_pkg::event_t            ev,
	output logic [sfr_pkg::BYTE_W-1:0] pay_byte,
	output logic [sfr_pkg::LEN_W-1:0]  pay_len,
	output sfr_pkg::reply_t            reply
);

	logic                       valid_q;
	logic                       seq_q, seq_d;
	sfr_pkg::event_t            ev_q, ev_d;
	logic [sfr_pkg::BYTE_W-1:0] byte_q, byte_d;
	logic [sfr_pkg::LEN_W-1:0]  len_q, len_d;
	sfr_pkg::reply_t            reply_q, reply_d;

	assign q_pop = !q_empty && (!valid_q || m_tready);

	always_comb begin
		seq_d   = seq_q;
		ev_d    = sfr_pkg::EV_BYTE;
		byte_d  = '0;
		len_d   = '0;
		reply_d = sfr_pkg::RP_NONE;
		case (q_data.kind)
			sfr_pkg::TK_BYTE: begin
				byte_d = q_data.data;
			end
			sfr_pkg::TK_HDR: begin
				ev_d    = sfr_pkg::EV_HDR;
				reply_d = sfr_pkg::RP_UA;
			end
			sfr_pkg::TK_END: begin
				len_d = q_data.len;
				if (q_data.ovf) begin
					ev_d = sfr_pkg::EV_OVF;
				end else if (q_data.bad) begin
					ev_d = sfr_pkg::EV_BAD;
					if (q_data.ctl_i0) begin
						reply_d = sfr_pkg::RP_REJ0;
						seq_d   = 1'b0;
					end else begin
						reply_d = sfr_pkg::RP_REJ1;
						seq_d   = 1'b1;
					end
				end else if (q_data.ctl_i0) begin
					ev_d    = !seq_q ? sfr_pkg::EV_GOOD : sfr_pkg::EV_DUP;
					reply_d = sfr_pkg::RP_RR1;
					seq_d   = 1'b1;
				end else if (q_data.ctl_i1) begin
					ev_d    = seq_q ? sfr_pkg::EV_GOOD : sfr_pkg::EV_DUP;
					reply_d = sfr_pkg::RP_RR0;
					seq_d   = 1'b0;
				end else begin
					ev_d = sfr_pkg::EV_GOOD;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seq_q   <= 1'b0;
			ev_q    <= sfr_pkg::EV_BYTE;
			byte_q  <= '0;
			len_q   <= '0;
			reply_q <= sfr_pkg::RP_NONE;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				seq_q   <= seq_d;
				ev_q    <= ev_d;
				byte_q  <= byte_d;
				len_q   <= len_d;
				reply_q <= reply_d;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign ev       = ev_q;
	assign pay_byte = byte_q;
	assign pay_len  = len_q;
	assign reply    = reply_q;

endmodule

/* hw/rtl/stuffed_frame_receiver_ack_top.sv */
// Byte-stuffed stop-and-wait frame receiver.
// s_* carries received line bytes, one word per byte. The parser hunts for
// the 0x7E flag, checks address, control and BCC1, removes escape stuffing
// and checks BCC2 at the closing flag. m_* carries events: payload bytes
// (delayed by one data byte so BCC2 is never passed on) and one frame-end
// event per frame with its length and the reply frame to send.
// cfg_* writes station address (index 0) and escape byte (index 1); it is
// always ready and should only be used while the receiver is idle.
// Throughput: one line byte per cycle while the queue is not full. An
// accepted byte that yields an event is written into the queue, then loaded
// into the output register that drives m_*. A four-entry queue sits between
// parser and reply stage; s_tready drops only when it is full, so a stalled
// m_tready backs up into the queue and then the input, with no word lost.
// Reset: hunting for a flag, expected sequence 0, address 0x03, escape 0x7D,
// queue and output register empty.
module stuffed_frame_receiver_ack_top #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [18:8] payload_length,
	                               // [21:19] reply_code, [23:22] zero
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                       accept;
	logic                       emit;
	sfr_pkg::token_t            push_tok, pop_tok;
	logic                       q_full, q_empty, q_pop;
	sfr_pkg::event_t            ev;
	logic [sfr_pkg::BYTE_W-1:0] pay_byte;
	logic [sfr_pkg::LEN_W-1:0]  pay_len;
	sfr_pkg::reply_t            reply;

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	sfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.rx_byte  (s_tdata),
		.emit     (emit),
		.token    (push_tok)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit),
		.push_data(push_tok),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_tok),
		.empty    (q_empty)
	);

	sfr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_tok),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.ev      (ev),
		.pay_byte(pay_byte),
		.pay_len (pay_len),
		.reply   (reply)
	);

	assign m_tuser = ev;
	assign m_tdata = {2'b00, reply, pay_len, pay_byte};

endmodule

/* tb/rx_event_checker.sv */
module rx_event_checker
	import sfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int          pending,
	output int          fails
);

	typedef enum logic [2:0] {
		HUNT, GOT_FLAG, GOT_ADDR, GOT_CTRL, GOT_BCC1, IN_DATA, IN_ESC
	} rx_phase_t;

	typedef struct {
		event_t      kind;
		logic [7:0]  data;
		logic [10:0] len;
		reply_t      reply;
	} rx_event_t;

	rx_event_t due_events[$];
	rx_event_t want;
	int        mismatches = 0;

	logic [7:0] station;
	logic [7:0] escape;
	rx_phase_t  phase;
	logic [7:0] ctl;
	logic       seq;
	logic [7:0] held;
	logic       held_ok;
	logic [7:0] chk;
	int         count;
	logic       ovf;

	function automatic void note_event(event_t k, logic [7:0] d, int n, reply_t r);
		rx_event_t e;
		e.kind  = k;
		e.data  = d;
		e.len   = n[10:0];
		e.reply = r;
		due_events.push_back(e);
	endfunction

	function automatic void take_data(logic [7:0] d);
		phase = IN_DATA;
		if (ovf)
			return;
		if (held_ok && count > MAX_PAYLOAD) begin
			ovf = 1'b1;
			return;
		end
		if (held_ok)
			note_event(EV_BYTE, held, 0, RP_NONE);
		chk ^= d;
		count++;
		held = d;
		held_ok = 1'b1;
	endfunction

	function automatic void close_frame();
		int len;
		len = count > 0 ? count - 1 : 0;
		phase = HUNT;
		if (ovf) begin
			note_event(EV_OVF, 8'h00, MAX_PAYLOAD, RP_NONE);
		end else if (chk != 8'h00 || count < 2) begin
			if (ctl == CTL_I0) begin
				seq = 1'b0;
				note_event(EV_BAD, 8'h00, len, RP_REJ0);
			end else begin
				seq = 1'b1;
				note_event(EV_BAD, 8'h00, len, RP_REJ1);
			end
		end else if (ctl == CTL_I0) begin
			note_event(seq == 1'b0 ? EV_GOOD : EV_DUP, 8'h00, len, RP_RR1);
			seq = 1'b1;
		end else if (ctl == CTL_I1) begin
			note_event(seq == 1'b1 ? EV_GOOD : EV_DUP, 8'h00, len, RP_RR0);
			seq = 1'b0;
		end else begin
			note_event(EV_GOOD, 8'h00, len, RP_NONE);
		end
	endfunction

	function automatic void absorb(logic [7:0] b);
		case (phase)
			GOT_FLAG: begin
				if (b == station)
					phase = GOT_ADDR;
				else if (b != FLAG_BYTE)
					phase = HUNT;
			end
			GOT_ADDR: begin
				if (b == CTL_I0 || b == CTL_I1 || b == CTL_SET) begin
					ctl = b;
					phase = GOT_CTRL;
				end else begin
					phase = b == FLAG_BYTE ? GOT_FLAG : HUNT;
				end
			end
			GOT_CTRL: begin
				if (b == (station ^ ctl)) begin
					phase = GOT_BCC1;
					held = 8'h00;
					held_ok = 1'b0;
					chk = 8'h00;
					count = 0;
					ovf = 1'b0;
				end else begin
					phase = b == FLAG_BYTE ? GOT_FLAG : HUNT;
				end
			end
			GOT_BCC1: begin
				if (b == escape) begin
					phase = IN_ESC;
				end else if (b == FLAG_BYTE) begin
					phase = HUNT;
					note_event(EV_HDR, 8'h00, 0, RP_UA);
				end else begin
					take_data(b);
				end
			end
			IN_ESC: take_data(b ^ UNSTUFF);
			IN_DATA: begin
				if (b == FLAG_BYTE)
					close_frame();
				else if (b == escape)
					phase = IN_ESC;
				else
					take_data(b);
			end
			default: phase = b == FLAG_BYTE ? GOT_FLAG : HUNT;
		endcase
	endfunction

	function automatic void check_field(string name, int exp, int act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station = ADDR_RESET;
			escape = ESCAPE_RESET;
			phase = HUNT;
			ctl = 8'h00;
			seq = 1'b0;
			held = 8'h00;
			held_ok = 1'b0;
			chk = 8'h00;
			count = 0;
			ovf = 1'b0;
			due_events.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STATION_ADDRESS)
					station = cfg_data;
				else
					escape = cfg_data;
			end
			if (s_tvalid && s_tready)
				absorb(s_tdata);
			if (m_tvalid && m_tready) begin
				if (due_events.size() == 0) begin
					$error("unexpected word: event_kind %0d, m_tdata %h", m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = due_events.pop_front();
					check_field("event_kind", want.kind, m_tuser);
					check_field("payload_byte", want.data, m_tdata[7:0]);
					check_field("payload_length", want.len, m_tdata[18:8]);
					check_field("reply_code", want.reply, m_tdata[21:19]);
				end
			end
			fails <= mismatches;
			pending <= due_events.size();
		end
	end

endmodule

/* tb/stuffed_frame_receiver_ack_top_tb.sv */
module stuffed_frame_receiver_ack_top_tb;
	import sfr_pkg::*;

	localparam int MAX_PAYLOAD = 1024;
	localparam int LIMIT = 400000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_reg_t    cfg_index = REG_STATION_ADDRESS;
	logic [7:0]  cfg_data  = 8'h00;

	int pending;
	int fails;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;
	logic [7:0] cur_station = ADDR_RESET;
	logic [7:0] cur_esc = ESCAPE_RESET;

	logic [7:0] warmup [21] = '{
		FLAG_BYTE, FLAG_BYTE, ADDR_RESET, CTL_SET, ADDR_RESET ^ CTL_SET, FLAG_BYTE,
		FLAG_BYTE, ADDR_RESET, CTL_I0, ADDR_RESET ^ CTL_I0, ESCAPE_RESET,
		FLAG_BYTE ^ UNSTUFF, 8'hFF, 8'h81, FLAG_BYTE,
		FLAG_BYTE, ADDR_RESET, CTL_I1, ADDR_RESET ^ CTL_I1, 8'h00, FLAG_BYTE
	};

	stuffed_frame_receiver_ack_top #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rx_event_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fails(fails)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= calm || $urandom_range(0, 99) >= 10;

	task automatic put_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic put_data(input logic [7:0] b);
		if (b == FLAG_BYTE || b == cur_esc) begin
			put_byte(cur_esc);
			put_byte(b ^ UNSTUFF);
		end else begin
			put_byte(b);
		end
	endtask

	// nfield counts the data field bytes, BCC2 included
	task automatic put_frame(input logic [7:0] addr, input logic [7:0] ctl,
			input logic [7:0] bcc1, input int nfield, input bit spoil);
		logic [7:0] sum;
		logic [7:0] d;
		int i;
		sum = 8'h00;
		put_byte(FLAG_BYTE);
		put_byte(addr);
		put_byte(ctl);
		put_byte(bcc1);
		for (i = 0; i < nfield - 1; i++) begin
			d = 8'($urandom);
			if ($urandom_range(0, 99) < 3) begin
				// escape ahead of an arbitrary raw byte
				put_byte(cur_esc);
				put_byte(d);
				sum ^= d ^ UNSTUFF;
			end else begin
				sum ^= d;
				put_data(d);
			end
		end
		if (nfield > 0)
			put_data(spoil ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
		put_byte(FLAG_BYTE);
	endtask

	task automatic random_frame();
		logic [7:0] addr;
		logic [7:0] ctl;
		logic [7:0] bcc1;
		int pick;
		int nfield;
		if ($urandom_range(0, 99) < 8)
			repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
		pick = $urandom_range(0, 2);
		ctl = pick == 0 ? CTL_I0 : pick == 1 ? CTL_I1 : CTL_SET;
		if ($urandom_range(0, 99) < 5)
			ctl = 8'($urandom);
		addr = $urandom_range(0, 99) < 5 ? 8'($urandom) : cur_station;
		bcc1 = $urandom_range(0, 99) < 5 ? 8'($urandom) : addr ^ ctl;
		pick = $urandom_range(0, 99);
		nfield = pick < 10 ? 0 : pick < 20 ? 1 : $urandom_range(2, 24);
		if ($urandom_range(0, 99) < 5)
			put_byte(FLAG_BYTE);
		put_frame(addr, ctl, bcc1, nfield, $urandom_range(0, 99) < 15);
	endtask

	task automatic drain();
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] addr, input logic [7:0] esc);
		cfg_valid <= 1'b1;
		cfg_index <= REG_STATION_ADDRESS;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ESCAPE_BYTE;
		cfg_data <= esc;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		int stop_at;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (warmup[i])
			put_byte(warmup[i]);
		for (p = 0; p < 5; p++) begin
			s_tvalid <= 1'b0;
			drain();
			case (p)
				0: begin
					cur_station = ADDR_RESET;
					cur_esc = ESCAPE_RESET;
				end
				1: begin
					cur_station = 8'h00;
					cur_esc = 8'h00;
				end
				2: begin
					cur_station = 8'hFF;
					cur_esc = 8'hFF;
				end
				default: begin
					cur_station = 8'($urandom);
					cur_esc = 8'($urandom);
				end
			endcase
			calm = p == 2;
			set_regs(cur_station, cur_esc);
			if (p == 0)
				put_frame(cur_station, CTL_I0, cur_station ^ CTL_I0, MAX_PAYLOAD + 2, 1'b0);
			stop_at = sent + 40;
			while (sent < stop_at)
				random_frame();
		end
		s_tvalid <= 1'b0;
		drain();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
